>>> rtl/core/crcfr_pkg.sv
// Shared types and constants for the CRC16 frame receiver.
// Holds command/status structs, state encodings and CRC constants.
// No dependencies.
`default_nettype none

package crcfr_pkg;

  // Default frame store depth
  localparam int FRAME_STORE_DEPTH_DEF = 64;

  // CRC16-MODBUS: init value, reflected polynomial, LSB mask
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;

  // Length byte bounds: MIN_LEN .. depth - LEN_MARGIN
  localparam int MIN_LEN    = 5;
  localparam int LEN_MARGIN = 3;

  // Register reset values
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hAA;
  localparam logic [7:0] ADDRESS_HIGH_RST  = 8'h60;
  localparam logic [7:0] ADDRESS_LOW_RST   = 8'h66;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_ADDRESS_HIGH  = 2'd2,
    REG_ADDRESS_LOW   = 2'd3
  } reg_index_t;

  // Frame parser phase, one-hot
  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_HEAD2   = 8'b0000_0010,
    PH_LENGTH  = 8'b0000_0100,
    PH_ADDR_H  = 8'b0000_1000,
    PH_ADDR_L  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_H   = 8'b0100_0000,
    PH_CRC_L   = 8'b1000_0000
  } phase_t;

  // Sequencer state, one-hot
  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_CRC  = 4'b0010,
    SQ_READ = 4'b0100,
    SQ_SEND = 4'b1000
  } seq_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;          // write byte to store, load CRC with it
    logic frame_start;    // with store: restart count and CRC
    logic crc_step;       // one CRC bit step
    logic count_clear;    // clear byte count
    logic flen_load;      // capture length byte
    logic crc_high_load;  // capture received CRC high byte
    logic crc_high_clear; // clear received CRC high byte
    logic emit_start;     // begin good-frame readout at index zero
    logic emit_err;       // set up the error result
    logic emit_next;      // advance readout index
    logic ram_rd;         // read store at readout index
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_ok;
    logic addr_h_match;
    logic addr_l_match;
    logic payload_done;
    logic crc_match;
    logic crc_last_bit;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/crcfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/crcfr_ctrl.sv
// Controller for the CRC16 frame receiver: frame phase and sequencer FSMs.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_accept,
  input  wire logic              out_ready,
  input  wire crcfr_pkg::status_t status,
  output crcfr_pkg::cmd_t        cmd,
  output logic                   in_ready,
  output logic                   out_valid
);

  crcfr_pkg::phase_t phase, phase_next;
  crcfr_pkg::seq_t   seq, seq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= crcfr_pkg::PH_HUNT;
      seq   <= crcfr_pkg::SQ_IDLE;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

  assign in_ready  = (seq == crcfr_pkg::SQ_IDLE);
  assign out_valid = (seq == crcfr_pkg::SQ_SEND);

  // Next state and command decode
  always_comb begin
    phase_next = phase;
    seq_next   = seq;
    cmd        = '0;
    case (seq)
      crcfr_pkg::SQ_IDLE: begin
        if (in_accept) begin
          case (phase)
            crcfr_pkg::PH_HUNT: begin
              if (status.hdr1_match) phase_next = crcfr_pkg::PH_HEAD2;
            end
            crcfr_pkg::PH_HEAD2: begin
              phase_next = status.hdr2_match ? crcfr_pkg::PH_LENGTH : crcfr_pkg::PH_HUNT;
            end
            crcfr_pkg::PH_LENGTH: begin
              cmd.flen_load = 1'b1;
              if (status.len_ok) begin
                cmd.store       = 1'b1;
                cmd.frame_start = 1'b1;
                phase_next      = crcfr_pkg::PH_ADDR_H;
                seq_next        = crcfr_pkg::SQ_CRC;
              end else begin
                phase_next = crcfr_pkg::PH_HUNT;
              end
            end
            crcfr_pkg::PH_ADDR_H: begin
              if (status.addr_h_match) begin
                cmd.store  = 1'b1;
                phase_next = crcfr_pkg::PH_ADDR_L;
                seq_next   = crcfr_pkg::SQ_CRC;
              end else begin
                cmd.count_clear = 1'b1;
                phase_next      = crcfr_pkg::PH_HUNT;
              end
            end
            crcfr_pkg::PH_ADDR_L: begin
              if (status.addr_l_match) begin
                cmd.store  = 1'b1;
                phase_next = crcfr_pkg::PH_PAYLOAD;
                seq_next   = crcfr_pkg::SQ_CRC;
              end else begin
                cmd.count_clear = 1'b1;
                phase_next      = crcfr_pkg::PH_HUNT;
              end
            end
            crcfr_pkg::PH_PAYLOAD: begin
              cmd.store = 1'b1;
              seq_next  = crcfr_pkg::SQ_CRC;
              if (status.payload_done) phase_next = crcfr_pkg::PH_CRC_H;
            end
            crcfr_pkg::PH_CRC_H: begin
              cmd.crc_high_load = 1'b1;
              phase_next        = crcfr_pkg::PH_CRC_L;
            end
            crcfr_pkg::PH_CRC_L: begin
              // End of frame: always back to the hunt
              cmd.count_clear    = 1'b1;
              cmd.crc_high_clear = 1'b1;
              phase_next         = crcfr_pkg::PH_HUNT;
              if (status.crc_match) begin
                cmd.emit_start = 1'b1;
                seq_next       = crcfr_pkg::SQ_READ;
              end else begin
                cmd.emit_err = 1'b1;
                seq_next     = crcfr_pkg::SQ_SEND;
              end
            end
            default: begin
              phase_next = crcfr_pkg::PH_HUNT;
            end
          endcase
        end
      end
      crcfr_pkg::SQ_CRC: begin
        cmd.crc_step = 1'b1;
        if (status.crc_last_bit) seq_next = crcfr_pkg::SQ_IDLE;
      end
      crcfr_pkg::SQ_READ: begin
        cmd.ram_rd = 1'b1;
        seq_next   = crcfr_pkg::SQ_SEND;
      end
      crcfr_pkg::SQ_SEND: begin
        if (out_ready) begin
          if (status.emit_last) begin
            seq_next = crcfr_pkg::SQ_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            seq_next      = crcfr_pkg::SQ_READ;
          end
        end
      end
      default: begin
        seq_next = crcfr_pkg::SQ_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/crcfr_datapath.sv
// Datapath for the CRC16 frame receiver: config registers, byte count,
// bit-serial CRC16-MODBUS, frame store and readout. Depends on crcfr_pkg
// and crcfr_ram.
`default_nettype none

module crcfr_datapath #(
  parameter int FRAME_STORE_DEPTH = crcfr_pkg::FRAME_STORE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic [7:0]         rx_byte,
  input  wire crcfr_pkg::cmd_t    cmd,
  output crcfr_pkg::status_t      status,
  output logic      [7:0]         out_byte,
  output logic                    out_last,
  output logic                    out_status
);

  localparam int IdxW = $clog2(FRAME_STORE_DEPTH);
  localparam logic [8:0] MaxLen = 9'(FRAME_STORE_DEPTH - crcfr_pkg::LEN_MARGIN);
  localparam logic [7:0] MinLen = 8'(crcfr_pkg::MIN_LEN);
  localparam logic [7:0] DepthW = 8'(FRAME_STORE_DEPTH);

  logic [7:0]      header_first, header_second, address_high, address_low;
  logic [7:0]      frame_length;
  logic [6:0]      byte_count;
  logic [7:0]      received_crc_high;
  logic [15:0]     running_crc;
  logic [2:0]      bit_count;
  logic [IdxW-1:0] emit_idx;
  logic            emit_err;
  logic [7:0]      ram_rd_data;

  logic [6:0]      eff_count;
  logic            store_ok;
  logic [6:0]      count_after;
  logic [15:0]     crc_base;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= crcfr_pkg::HEADER_FIRST_RST;
      header_second <= crcfr_pkg::HEADER_SECOND_RST;
      address_high  <= crcfr_pkg::ADDRESS_HIGH_RST;
      address_low   <= crcfr_pkg::ADDRESS_LOW_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        crcfr_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        crcfr_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        crcfr_pkg::REG_ADDRESS_HIGH:  address_high  <= cfg_data;
        crcfr_pkg::REG_ADDRESS_LOW:   address_low   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store index: a new frame restarts at zero
  assign eff_count   = cmd.frame_start ? 7'd0 : byte_count;
  assign store_ok    = {1'b0, eff_count} < DepthW;
  assign count_after = store_ok ? eff_count + 7'd1 : eff_count;
  assign crc_base    = cmd.frame_start ? crcfr_pkg::CRC_INIT : running_crc;

  // Frame length, byte count, received CRC high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length      <= '0;
      byte_count        <= '0;
      received_crc_high <= '0;
    end else begin
      if (cmd.flen_load) frame_length <= rx_byte;
      if (cmd.count_clear) begin
        byte_count <= '0;
      end else if (cmd.store) begin
        byte_count <= count_after;
      end
      if (cmd.crc_high_clear) begin
        received_crc_high <= '0;
      end else if (cmd.crc_high_load) begin
        received_crc_high <= rx_byte;
      end
    end
  end

  // Bit-serial CRC: xor the byte in, then eight shift steps
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crcfr_pkg::CRC_INIT;
      bit_count   <= '0;
    end else if (cmd.store) begin
      running_crc <= crc_base ^ {8'h00, rx_byte};
      bit_count   <= '0;
    end else if (cmd.crc_step) begin
      if ((running_crc & crcfr_pkg::CRC_LSB) != 16'h0000) begin
        running_crc <= (running_crc >> 1) ^ crcfr_pkg::CRC_POLY;
      end else begin
        running_crc <= running_crc >> 1;
      end
      bit_count <= bit_count + 3'd1;
    end
  end

  // Readout index and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
      emit_err <= 1'b0;
    end else if (cmd.emit_start) begin
      emit_idx <= '0;
      emit_err <= 1'b0;
    end else if (cmd.emit_err) begin
      emit_err <= 1'b1;
    end else if (cmd.emit_next) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  crcfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store && store_ok),
    .wr_addr (eff_count[IdxW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.ram_rd),
    .rd_addr (emit_idx),
    .rd_data (ram_rd_data)
  );

  // Status to controller
  always_comb begin
    status              = '0;
    status.hdr1_match   = (rx_byte == header_first);
    status.hdr2_match   = (rx_byte == header_second);
    status.len_ok       = (rx_byte >= MinLen) && ({1'b0, rx_byte} <= MaxLen);
    status.addr_h_match = (rx_byte == address_high);
    status.addr_l_match = (rx_byte == address_low);
    status.payload_done = {2'b00, count_after} >= ({1'b0, frame_length} + 9'd1);
    status.crc_match    = ({received_crc_high, rx_byte} == running_crc);
    status.crc_last_bit = (bit_count == 3'd7);
    status.emit_last    = emit_err || (8'(emit_idx) == frame_length);
  end

  // Result fields
  assign out_byte   = emit_err ? 8'h00 : ram_rd_data;
  assign out_last   = status.emit_last;
  assign out_status = emit_err;

endmodule

`default_nettype wire

>>> rtl/core/crc16_frame_receiver.sv
// Top level of the CRC16 frame receiver: controller plus datapath.
// Depends on crcfr_pkg, crcfr_ctrl, crcfr_datapath, crcfr_ram.
//
//  channel   | direction | transfer contents
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | tdata[7:0] rx_byte
//  m_axis    | out       | tdata[7:0] out_byte, tlast last, tuser[0] status
//  cfg       | in        | cfg_index register, cfg_data[7:0] value
//
// A byte that is not stored (header, CRC, rejected) does not go through the CRC unit. A stored
// byte (length, address, payload) gets one load and eight CRC bit steps in
// the serial CRC unit, and no input is taken until they end. Each good-frame
// result byte is first read from the registered store and then presented;
// the error result is presented in the cycle after the CRC low byte. m_tready low holds a result.
// Input is not taken while a frame is being read out.
// Reset (rst, synchronous) returns to the header hunt with default registers.
`default_nettype none

module crc16_frame_receiver #(
  parameter int FRAME_STORE_DEPTH = crcfr_pkg::FRAME_STORE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  output logic      [0:0] m_tuser,   // [0] status
  input  wire logic       cfg_wen,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  crcfr_pkg::cmd_t    cmd;
  crcfr_pkg::status_t status;
  logic               out_status;

  crcfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (s_tvalid && s_tready),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  crcfr_datapath #(
    .FRAME_STORE_DEPTH (FRAME_STORE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_status (out_status)
  );

  assign m_tuser[0] = out_status;

endmodule

`default_nettype wire
